### sv/new_radio_delta_scorer_top_macros.svh
// Assertion macros for the new radio delta scorer.
// Included by the top level; expects clk and rst_n in scope.
`ifndef NEW_RADIO_DELTA_SCORER_TOP_MACROS_SVH
`define NEW_RADIO_DELTA_SCORER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define NRDS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define NRDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/nrds_pkg.sv
// Shared types, constants and tables for the new radio delta scorer.
// No dependencies; imported by every module of the block.
package nrds_pkg;

  localparam int TABLE_DEPTH     = 64;
  localparam int VENDOR_PREFIXES = 13;
  localparam int IDX_W           = $clog2(TABLE_DEPTH);
  localparam int CNT_W           = $clog2(TABLE_DEPTH + 1);
  localparam int ADDR_W          = 48;
  localparam int SCORE_W         = 7;
  localparam int HIT_W           = 7;
  localparam int SUM_W           = 8;
  localparam int CFG_IDX_W       = 2;

  localparam logic [SUM_W-1:0] SCORE_BASE   = 8'd35;
  localparam logic [SUM_W-1:0] SCORE_VENDOR = 8'd45;
  localparam logic [SUM_W-1:0] SCORE_LOCAL  = 8'd10;
  localparam logic [SUM_W-1:0] SCORE_TELL   = 8'd55;
  localparam logic [SUM_W-1:0] SCORE_HIDDEN = 8'd15;
  localparam logic [SUM_W-1:0] SCORE_OPEN   = 8'd5;
  localparam logic [SUM_W-1:0] SCORE_MAX    = 8'd100;

  localparam logic [SCORE_W-1:0] DANGER_RESET     = 7'd70;
  localparam logic [SCORE_W-1:0] SUSPICIOUS_RESET = 7'd45;

  // Bit of the address that marks a locally administered first octet.
  localparam int LOCAL_ADMIN_BIT = 41;
  localparam logic [3:0] AUTH_OPEN = 4'd0;

  localparam logic [23:0] VENDOR_OUI [VENDOR_PREFIXES] = '{
    24'h18FE34, 24'h240AC4, 24'h3C7160, 24'h7CDFA1, 24'h8CAAB5,
    24'hA4CF12, 24'hB4E62D, 24'hDC4F22, 24'hE868E7, 24'h84F3EB,
    24'h2462AB, 24'h10520C, 24'h9C9C1F
  };

  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_BASE  = 2'd1,
    MODE_CAND  = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DANGER     = 2'd0,
    CFG_SUSPICIOUS = 2'd1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    REASON_NEW    = 2'd0,
    REASON_VENDOR = 2'd1,
    REASON_TELL   = 2'd2
  } reason_t;

  typedef enum logic [1:0] {
    VERDICT_CLEAN      = 2'd0,
    VERDICT_SUSPICIOUS = 2'd1,
    VERDICT_DANGEROUS  = 2'd2
  } verdict_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ASRCH,
    ST_BSRCH,
    ST_SCORE
  } state_t;

  // Input item payload as in_tdata; members listed from the highest bit down.
  typedef struct packed {
    logic        name_tell;
    logic [3:0]  auth_mode;
    logic        is_hidden;
    addr_t       station_address;
  } item_t;

  // Scoring unit results.
  typedef struct packed {
    logic [SCORE_W-1:0] score;
    reason_t            reason;
    logic [SCORE_W-1:0] worst;
    verdict_t           verdict;
  } score_t;

  // Result item payload as out_tdata; members listed from the highest bit down.
  typedef struct packed {
    verdict_t           verdict;
    logic [SCORE_W-1:0] worst_score;
    logic [HIT_W-1:0]   hit_total;
    reason_t            reason_code;
    logic [SCORE_W-1:0] threat_score;
    addr_t              hit_address;
  } result_t;

endpackage

### sv/nrds_table.sv
// Address table memory: one write port, one registered read port.
// Depends on nrds_pkg for depth and address type.
module nrds_table (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [nrds_pkg::IDX_W-1:0] wr_idx,
  input  nrds_pkg::addr_t        wr_data,
  input  logic                   rd_en,
  input  logic [nrds_pkg::IDX_W-1:0] rd_idx,
  output nrds_pkg::addr_t        rd_data
);
  import nrds_pkg::*;

  addr_t mem_r [TABLE_DEPTH];
  addr_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_idx];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### sv/nrds_score.sv
// Threat scoring unit: signature score, reason, running worst and verdict.
// Depends on nrds_pkg for constants, vendor prefix table and types.
module nrds_score (
  input  nrds_pkg::item_t                 item,
  input  logic [nrds_pkg::SCORE_W-1:0]    worst_in,
  input  logic [nrds_pkg::SCORE_W-1:0]    danger_thr,
  input  logic [nrds_pkg::SCORE_W-1:0]    susp_thr,
  output nrds_pkg::score_t                res
);
  import nrds_pkg::*;

  logic               vendor_hit;
  logic [SUM_W-1:0]   sum;
  logic [SCORE_W-1:0] score;
  logic [SCORE_W-1:0] worst;

  // Compare the upper three octets against each known prefix.
  always_comb begin
    vendor_hit = 1'b0;
    for (int i = 0; i < VENDOR_PREFIXES; i++) begin
      if (item.station_address[ADDR_W-1 -: 24] == VENDOR_OUI[i]) begin
        vendor_hit = 1'b1;
      end
    end
  end

  always_comb begin
    sum = SCORE_BASE;
    if (vendor_hit)                             sum = sum + SCORE_VENDOR;
    if (item.station_address[LOCAL_ADMIN_BIT])  sum = sum + SCORE_LOCAL;
    if (item.name_tell)                         sum = sum + SCORE_TELL;
    if (item.is_hidden)                         sum = sum + SCORE_HIDDEN;
    if (item.auth_mode == AUTH_OPEN)            sum = sum + SCORE_OPEN;
  end

  assign score = (sum > SCORE_MAX) ? SCORE_W'(SCORE_MAX) : sum[SCORE_W-1:0];
  assign worst = (score > worst_in) ? score : worst_in;

  always_comb begin
    res.score = score;
    res.worst = worst;
    priority if (item.name_tell) begin
      res.reason = REASON_TELL;
    end else if (vendor_hit) begin
      res.reason = REASON_VENDOR;
    end else begin
      res.reason = REASON_NEW;
    end
    priority if (worst >= danger_thr) begin
      res.verdict = VERDICT_DANGEROUS;
    end else if (worst >= susp_thr) begin
      res.verdict = VERDICT_SUSPICIOUS;
    end else begin
      res.verdict = VERDICT_CLEAN;
    end
  end

endmodule

### sv/new_radio_delta_scorer_top.sv
// New radio delta scorer, top level: sequencer, shared address comparator,
// counters and result register. Depends on nrds_pkg, nrds_table, nrds_score.
//
//   Channel | Direction | Handshake             | Payload
//   --------+-----------+-----------------------+----------------------------------
//   in_     | sink      | in_tvalid / in_tready | tuser: mode; tdata: candidate item
//   out_    | source    | out_tvalid/out_tready | tdata: one hit result
//   cfg_    | sink      | cfg_valid / cfg_ready | cfg_index, cfg_data thresholds
//
// Clear, baseline record and unused-mode items finish in idle. A candidate
// scans the after table and then the baseline table, one entry a cycle
// through the single 48-bit comparator fed by the registered memory reads;
// a match ends the scan early, and a full after table skips the baseline scan.
// Reset (rst_n low, synchronous) zeroes all counts, the worst score and the
// control state and loads the threshold defaults; table contents need none.
// A result waits in the output register while out_tready is low; the next
// item is still taken, and the sequencer holds in the scoring step only if
// it has a second result and the first is still unclaimed.
module new_radio_delta_scorer_top (
  input  logic        clk,
  input  logic        rst_n,
  // in_tuser: [1:0] mode
  // in_tdata: [47:0] station_address, [48] is_hidden, [52:49] auth_mode,
  //           [53] name_tell, [55:54] zero
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,
  input  logic [55:0] in_tdata,
  // out_tdata: [47:0] hit_address, [54:48] threat_score, [56:55] reason_code,
  //            [63:57] hit_total, [70:64] worst_score, [72:71] verdict,
  //            [79:73] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [nrds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nrds_pkg::SCORE_W-1:0]   cfg_data
);
  import nrds_pkg::*;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  state_t             state_r, state_nxt;
  item_t              item_r;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic [CNT_W-1:0]   a_cnt_r, a_cnt_nxt;
  logic [CNT_W-1:0]   b_cnt_r, b_cnt_nxt;
  logic [CNT_W-1:0]   hit_cnt_r, hit_cnt_nxt;
  logic [SCORE_W-1:0] worst_r, worst_nxt;
  logic [SCORE_W-1:0] danger_r, susp_r;
  logic               out_vld_r, out_vld_nxt;
  result_t            out_res_r;

  logic     in_acc;
  mode_t    in_mode;
  item_t    in_item;
  addr_t    a_rd, b_rd, rd_sel;
  logic     a_wr, b_wr, a_rd_en, b_rd_en, issue;
  logic     match, scan_done;
  logic [CNT_W-1:0] cur_cnt;
  logic     out_load;
  score_t   sres;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_mode   = mode_t'(in_tuser);
  assign in_item   = item_t'(in_tdata[$bits(item_t)-1:0]);
  assign cfg_ready = 1'b1;

  // Thresholds
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      danger_r <= DANGER_RESET;
      susp_r   <= SUSPICIOUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DANGER:     danger_r <= cfg_data;
        CFG_SUSPICIOUS: susp_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Table memories; both addressed at the scan index, only one is read and compared.
  nrds_table u_after (
    .clk     (clk),
    .wr_en   (a_wr),
    .wr_idx  (a_cnt_r[IDX_W-1:0]),
    .wr_data (item_r.station_address),
    .rd_en   (a_rd_en),
    .rd_idx  (idx_r[IDX_W-1:0]),
    .rd_data (a_rd)
  );

  nrds_table u_base (
    .clk     (clk),
    .wr_en   (b_wr),
    .wr_idx  (b_cnt_r[IDX_W-1:0]),
    .wr_data (in_item.station_address),
    .rd_en   (b_rd_en),
    .rd_idx  (idx_r[IDX_W-1:0]),
    .rd_data (b_rd)
  );

  nrds_score u_score (
    .item       (item_r),
    .worst_in   (worst_r),
    .danger_thr (danger_r),
    .susp_thr   (susp_r),
    .res        (sres)
  );

  // Shared comparator: the read issued last cycle against the candidate.
  assign rd_sel    = (state_r == ST_BSRCH) ? b_rd : a_rd;
  assign cur_cnt   = (state_r == ST_BSRCH) ? b_cnt_r : a_cnt_r;
  assign match     = cmp_vld_r && (rd_sel == item_r.station_address);
  assign scan_done = (idx_r == cur_cnt) && !cmp_vld_r;
  assign issue     = (idx_r < cur_cnt) && !match;
  assign out_load  = (state_r == ST_SCORE) && (!out_vld_r || out_tready);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_mode == MODE_CAND) state_nxt = ST_ASRCH;
      end
      ST_ASRCH: begin
        priority if (match) begin
          state_nxt = ST_IDLE;
        end else if (scan_done) begin
          state_nxt = (a_cnt_r >= DEPTH_CNT) ? ST_IDLE : ST_BSRCH;
        end
      end
      ST_BSRCH: begin
        priority if (match) begin
          state_nxt = ST_IDLE;
        end else if (scan_done) begin
          state_nxt = (hit_cnt_r >= DEPTH_CNT) ? ST_IDLE : ST_SCORE;
        end
      end
      ST_SCORE: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath controls
  always_comb begin
    idx_nxt     = '0;
    cmp_vld_nxt = 1'b0;
    a_cnt_nxt   = a_cnt_r;
    b_cnt_nxt   = b_cnt_r;
    hit_cnt_nxt = hit_cnt_r;
    worst_nxt   = worst_r;
    a_wr        = 1'b0;
    b_wr        = 1'b0;
    a_rd_en     = 1'b0;
    b_rd_en     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_mode)
            MODE_CLEAR: begin
              a_cnt_nxt   = '0;
              b_cnt_nxt   = '0;
              hit_cnt_nxt = '0;
              worst_nxt   = '0;
            end
            MODE_BASE: begin
              if (b_cnt_r < DEPTH_CNT) begin
                b_wr      = 1'b1;
                b_cnt_nxt = b_cnt_r + 1'b1;
              end
            end
            MODE_CAND: ;
            default: ;
          endcase
        end
      end
      ST_ASRCH: begin
        if (scan_done && !match && a_cnt_r < DEPTH_CNT) begin
          // Store the new candidate, then scan the baseline from entry zero.
          a_wr      = 1'b1;
          a_cnt_nxt = a_cnt_r + 1'b1;
        end else if (issue) begin
          a_rd_en     = 1'b1;
          idx_nxt     = idx_r + 1'b1;
          cmp_vld_nxt = 1'b1;
        end else begin
          idx_nxt = idx_r;
        end
      end
      ST_BSRCH: begin
        if (issue) begin
          b_rd_en     = 1'b1;
          idx_nxt     = idx_r + 1'b1;
          cmp_vld_nxt = 1'b1;
        end else begin
          idx_nxt = idx_r;
        end
      end
      ST_SCORE: begin
        if (out_load) begin
          hit_cnt_nxt = hit_cnt_r + 1'b1;
          worst_nxt   = sres.worst;
        end
      end
      default: ;
    endcase
  end

  assign out_vld_nxt = out_load || (out_vld_r && !out_tready);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      idx_r     <= '0;
      cmp_vld_r <= 1'b0;
      a_cnt_r   <= '0;
      b_cnt_r   <= '0;
      hit_cnt_r <= '0;
      worst_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      a_cnt_r   <= a_cnt_nxt;
      b_cnt_r   <= b_cnt_nxt;
      hit_cnt_r <= hit_cnt_nxt;
      worst_r   <= worst_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers: hold the candidate, load the result.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_item;
    end
    if (out_load) begin
      out_res_r.hit_address  <= item_r.station_address;
      out_res_r.threat_score <= sres.score;
      out_res_r.reason_code  <= sres.reason;
      out_res_r.hit_total    <= HIT_W'(hit_cnt_nxt);
      out_res_r.worst_score  <= sres.worst;
      out_res_r.verdict      <= sres.verdict;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {(80 - $bits(result_t))'(0), out_res_r};

  // Checks
  `include "new_radio_delta_scorer_top_macros.svh"

  `NRDS_ASSERT_NOW(a_cnt_bound, 1'b1, (a_cnt_r <= DEPTH_CNT) && (b_cnt_r <= DEPTH_CNT) && (hit_cnt_r <= DEPTH_CNT), "table or hit count beyond depth")
  `NRDS_ASSERT_NOW(a_scan_bound, (state_r == ST_ASRCH) || (state_r == ST_BSRCH), idx_r <= cur_cnt, "scan index beyond table count")
  `NRDS_ASSERT_NEXT(a_hit_step, out_load, hit_cnt_r == $past(hit_cnt_r) + 1'b1, "result loaded without hit count step")
  `NRDS_ASSERT_NEXT(a_worst_mono, !(in_acc && in_mode == MODE_CLEAR), worst_r >= $past(worst_r), "worst score fell without clear")

endmodule
